/* rtl/id3fp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 frame parser package
// Shared widths, result kinds, the result record and the frame slot lookup.
// ----------------------------------------------------------------------------
package id3fp_pkg;

  // Width of the tag length and of every count derived from it.
  localparam int LENGTH_BITS = 28;
  localparam int SIZE_W      = 28;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [2:0]        slot;
    logic [7:0]        data;
    logic [SIZE_W-1:0] size;
    logic              last;
  } result_t;

  typedef struct packed {
    logic       known;
    logic [2:0] slot;
  } slot_t;

  localparam logic [31:0] IDS_V3 [8] = '{
    32'h41504943, 32'h434F4D4D, 32'h54414C42, 32'h54495432,
    32'h54504531, 32'h54594552, 32'h5452434B, 32'h55534C54
  };

  localparam logic [31:0] ID_TT2 = 32'h00545432;
  localparam logic [31:0] ID_TP1 = 32'h00545031;
  localparam logic [31:0] ID_TAL = 32'h0054414C;
  localparam logic [31:0] ID_COM = 32'h00434F4D;

  localparam logic [2:0] SLOT_COMM = 3'd1;
  localparam logic [2:0] SLOT_TALB = 3'd2;
  localparam logic [2:0] SLOT_TIT2 = 3'd3;
  localparam logic [2:0] SLOT_TPE1 = 3'd4;

  // Version 2 frames use three-character IDs that map onto the long slots.
  function automatic slot_t find_slot(logic is_v2, logic [31:0] id);
    slot_t r;
    r = '0;
    if (is_v2) begin
      if (id == ID_TT2) r = '{known: 1'b1, slot: SLOT_TIT2};
      else if (id == ID_TP1) r = '{known: 1'b1, slot: SLOT_TPE1};
      else if (id == ID_TAL) r = '{known: 1'b1, slot: SLOT_TALB};
      else if (id == ID_COM) r = '{known: 1'b1, slot: SLOT_COMM};
    end else begin
      for (int i = 7; i >= 0; i--) begin
        if (IDS_V3[i] == id) r = '{known: 1'b1, slot: 3'(i)};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/id3v2_frame_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 frame parser
// Walks an ID3v2 tag one byte per beat; emits the payload bytes of the known
// text and picture frames with their slot, plus empty frames, end and errors.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_ready   data_byte, tag_start
//  output   out_valid / out_ready out_kind, slot, payload_byte, frame_size,
//                                 last_in_frame
//
// One byte per clock while results are taken. A beat is first held in the
// input register, then the parse step updates the state and loads the output
// register, so every result passes through both registers on its way out.
// Reset returns the parser to idle; bytes before a tag_start beat are dropped.
// While the output stalls, bytes that yield no result keep flowing; a byte
// that yields one waits in the input register and holds off the input.
// ----------------------------------------------------------------------------
module id3v2_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        tag_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [2:0]       slot,
  output logic [7:0]       payload_byte,
  output logic [27:0]      frame_size,
  output logic             last_in_frame
);
  import id3fp_pkg::*;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_start;
  logic       fire;
  result_t    res;
  result_t    out_q;

  // A step that yields no result may go ahead even while the output stalls.
  assign fire     = in_q_valid && (!out_valid || out_ready || !res.valid);
  assign in_ready = !in_q_valid || fire;

  id3fp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_q_byte),
    .tag_start (in_q_start),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) in_q_valid <= in_valid;
      if (fire && res.valid) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (in_ready && in_valid) begin
      in_q_byte  <= data_byte;
      in_q_start <= tag_start;
    end
    if (fire && res.valid) out_q <= res;
  end

  assign out_kind      = out_q.kind;
  assign slot          = out_q.slot;
  assign payload_byte  = out_q.data;
  assign frame_size    = out_q.size;
  assign last_in_frame = out_q.last;

endmodule
`default_nettype wire

/* rtl/id3fp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 frame parser core
// Holds the parse state and advances it by one byte per fire, producing at
// most one result record for that byte.
// ----------------------------------------------------------------------------
module id3fp_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [7:0]        data_byte,
  input  wire logic              tag_start,
  output id3fp_pkg::result_t     res
);
  import id3fp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TAGHDR, PH_FRAMEHDR, PH_PAYLOAD, PH_SKIP
  } phase_t;

  localparam logic [1:0] VER_NONE = 2'd0;
  localparam logic [1:0] VER_2    = 2'd2;
  localparam logic [1:0] VER_3    = 2'd3;

  localparam logic [3:0] TAG_HDR_LAST  = 4'd9;
  localparam logic [3:0] TAG_VER_BYTE  = 4'd3;
  localparam logic [3:0] TAG_ID_BYTES  = 4'd3;
  localparam logic [3:0] TAG_LEN_FIRST = 4'd6;
  localparam logic [3:0] V2_HDR_LAST   = 4'd5;
  localparam logic [3:0] V3_HDR_LAST   = 4'd9;
  localparam logic [3:0] V2_ID_BYTES   = 4'd3;
  localparam logic [3:0] V3_ID_BYTES   = 4'd4;

  localparam logic [23:0]            TAG_MAGIC = 24'h494433;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE   = LENGTH_BITS'(1);

  phase_t                 phase, phase_next;
  logic [1:0]             tag_version, tag_version_next;
  logic [3:0]             header_count, header_count_next;
  logic [31:0]            frame_id, frame_id_next;
  logic [31:0]            size_accum, size_accum_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;
  // Bytes left in the tag, counted down instead of an offset against a length.
  logic [LENGTH_BITS-1:0] tag_left, tag_left_next;
  logic [LENGTH_BITS-1:0] frame_room, frame_room_next;
  slot_t                  current_slot, current_slot_next;

  // The step is worked out for whatever sits in the input register; the
  // state only takes it when the byte fires.
  always_comb begin
    phase_t                 c_ph;
    logic [1:0]             c_ver;
    logic [3:0]             c_hc;
    logic [31:0]            c_fid;
    logic [31:0]            c_acc;
    logic [LENGTH_BITS-1:0] c_pl;
    logic [LENGTH_BITS-1:0] c_left;
    logic [27:0]            len28;
    logic                   v2;
    logic [3:0]             hlast;
    logic [3:0]             idlen;
    logic [31:0]            fid_w;
    logic [31:0]            acc_w;
    logic [LENGTH_BITS-1:0] fs;
    logic [LENGTH_BITS-1:0] pl_dec;
    slot_t                  lk;

    phase_next        = phase;
    tag_version_next  = tag_version;
    header_count_next = header_count;
    frame_id_next     = frame_id;
    size_accum_next   = size_accum;
    payload_left_next = payload_left;
    tag_left_next     = tag_left;
    frame_room_next   = frame_room;
    current_slot_next = current_slot;
    res               = '0;

    // A start byte wipes the old tag before the byte itself is parsed.
    c_ph   = tag_start ? PH_TAGHDR : phase;
    c_ver  = tag_start ? VER_NONE : tag_version;
    c_hc   = tag_start ? 4'd0 : header_count;
    c_fid  = tag_start ? 32'd0 : frame_id;
    c_acc  = tag_start ? 32'd0 : size_accum;
    c_pl   = tag_start ? '0 : payload_left;
    c_left = tag_start ? '0 : tag_left;

    len28  = {c_acc[20:0], data_byte[6:0]};
    v2     = (c_ver == VER_2);
    hlast  = v2 ? V2_HDR_LAST : V3_HDR_LAST;
    idlen  = v2 ? V2_ID_BYTES : V3_ID_BYTES;
    fid_w  = (c_hc == 4'd0) ? {24'd0, data_byte} :
             (c_hc < idlen) ? {c_fid[23:0], data_byte} : c_fid;
    acc_w  = (c_hc == idlen) ? {24'd0, data_byte} :
             ((c_hc > idlen) && (c_hc < (idlen << 1))) ? {c_acc[23:0], data_byte} : c_acc;
    fs     = (acc_w > 32'(frame_room)) ? frame_room : acc_w[LENGTH_BITS-1:0];
    lk     = find_slot(v2, fid_w);
    pl_dec = c_pl - LEN_ONE;

    if (tag_start) begin
      phase_next        = PH_TAGHDR;
      tag_version_next  = VER_NONE;
      header_count_next = 4'd0;
      frame_id_next     = 32'd0;
      size_accum_next   = 32'd0;
      payload_left_next = '0;
      tag_left_next     = '0;
      current_slot_next = '0;
    end
    unique case (c_ph)
      PH_IDLE: begin
      end
      PH_TAGHDR: begin
        if (c_hc < TAG_ID_BYTES) begin
          frame_id_next = {8'd0, c_fid[15:0], data_byte};
        end else if (c_hc == TAG_VER_BYTE) begin
          tag_version_next = (data_byte == 8'd2) ? VER_2 :
                             ((data_byte == 8'd3) || (data_byte == 8'd4)) ? VER_3 : VER_NONE;
        end else if (c_hc >= TAG_LEN_FIRST) begin
          size_accum_next = {4'd0, len28};
        end
        if (c_hc < TAG_HDR_LAST) begin
          header_count_next = c_hc + 4'd1;
        end else begin
          header_count_next = 4'd0;
          frame_id_next     = 32'd0;
          size_accum_next   = 32'd0;
          if ((c_fid[23:0] != TAG_MAGIC) || (c_ver == VER_NONE)) begin
            phase_next = PH_IDLE;
            res.valid  = 1'b1;
            res.kind   = KIND_ERROR;
          end else begin
            phase_next    = PH_FRAMEHDR;
            tag_left_next = (len28 > 28'(LEN_MAX)) ? LEN_MAX : len28[LENGTH_BITS-1:0];
          end
        end
      end
      PH_FRAMEHDR, PH_PAYLOAD, PH_SKIP: begin
        if ((c_left == '0) ||
            ((c_ph == PH_FRAMEHDR) && (c_hc == 4'd0) && (data_byte == 8'd0))) begin
          phase_next        = PH_IDLE;
          header_count_next = 4'd0;
          res.valid         = 1'b1;
          res.kind          = KIND_END;
        end else if (c_ph == PH_FRAMEHDR) begin
          frame_id_next   = fid_w;
          size_accum_next = acc_w;
          tag_left_next   = c_left - LEN_ONE;
          if (c_hc == 4'd0) frame_room_next = c_left;
          if (c_hc < hlast) begin
            header_count_next = c_hc + 4'd1;
          end else begin
            header_count_next = 4'd0;
            current_slot_next = lk;
            size_accum_next   = 32'(fs);
            if (fs == '0) begin
              if (lk.known) begin
                res.valid = 1'b1;
                res.kind  = KIND_EMPTY;
                res.slot  = lk.slot;
              end
            end else begin
              payload_left_next = fs;
              phase_next        = lk.known ? PH_PAYLOAD : PH_SKIP;
            end
          end
        end else begin
          payload_left_next = pl_dec;
          tag_left_next     = c_left - LEN_ONE;
          if (pl_dec == '0) begin
            phase_next        = PH_FRAMEHDR;
            header_count_next = 4'd0;
          end
          if (c_ph == PH_PAYLOAD) begin
            res.valid = 1'b1;
            res.kind  = KIND_PAYLOAD;
            res.slot  = current_slot.slot;
            res.data  = data_byte;
            res.size  = SIZE_W'(c_acc[LENGTH_BITS-1:0]);
            res.last  = (c_pl <= LEN_ONE) || (c_left == LEN_ONE);
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_count <= 4'd0;
      tag_version  <= VER_NONE;
    end else if (fire) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      tag_version  <= tag_version_next;
    end
    if (fire) begin
      frame_id     <= frame_id_next;
      size_accum   <= size_accum_next;
      payload_left <= payload_left_next;
      tag_left     <= tag_left_next;
      frame_room   <= frame_room_next;
      current_slot <= current_slot_next;
    end
  end

  // While a frame body is walked there is always at least one byte still owed.
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_PAYLOAD) || (phase == PH_SKIP)) |-> (payload_left != '0))
    else $error("frame body phase with no bytes left");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (header_count == 4'd0))
    else $error("header count not cleared while idle");

  a_tag_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAGHDR) |-> (header_count <= TAG_HDR_LAST))
    else $error("tag header count past its last byte");

  a_v2_count: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_FRAMEHDR) && (tag_version == VER_2)) |-> (header_count <= V2_HDR_LAST))
    else $error("version 2 frame header count past its last byte");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && res.valid && ((res.kind == KIND_END) || (res.kind == KIND_ERROR)))
      |=> (phase == PH_IDLE))
    else $error("tag end or header error did not return to idle");

endmodule
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 frame parser testbench
// Feeds byte streams of ID3v2 tags through the parser: a short table of
// hand-picked beats, then random tags that are mostly well formed, with bad
// headers, cut headers, unknown and empty frames, padding and oversized
// frames mixed in. Results are checked against the table or a parser model.
// ----------------------------------------------------------------------------
module tb;
  import id3fp_pkg::*;

  localparam int          RANDOM_BEATS = 1900;
  localparam int          LONG_HOLD    = 400;
  localparam logic [3:0]  NO_SLOT      = 4'd8;
  localparam logic [31:0] TAG_MAGIC    = 32'h00494433;

  localparam logic [31:0] V3_IDS [8] = '{
    32'h41504943, 32'h434F4D4D, 32'h54414C42, 32'h54495432,
    32'h54504531, 32'h54594552, 32'h5452434B, 32'h55534C54
  };
  // Three-character IDs: TT2, TP1, TAL, COM and the slots they land in.
  localparam logic [31:0] V2_IDS [4] = '{
    32'h00545432, 32'h00545031, 32'h0054414C, 32'h00434F4D
  };
  localparam logic [3:0] V2_SLOTS [4] = '{4'd3, 4'd4, 4'd2, 4'd1};

  typedef enum logic [2:0] {
    PS_IDLE, PS_TAG_HDR, PS_FRAME_HDR, PS_PAYLOAD, PS_SKIP
  } parse_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  slot;
    logic [7:0]  data;
    logic [27:0] size;
    logic        last;
  } parse_result_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_check_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          start;
    row_check_t    check;
    parse_result_t res;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } tag_byte_t;

  localparam parse_result_t NO_RESULT = '{KIND_PAYLOAD, 3'd0, 8'd0, 28'd0, 1'b0};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        tag_start;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [2:0]  slot;
  logic [7:0]  payload_byte;
  logic [27:0] frame_size;
  logic        last_in_frame;

  id3v2_frame_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .tag_start(tag_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .slot(slot), .payload_byte(payload_byte),
    .frame_size(frame_size), .last_in_frame(last_in_frame)
  );

  // Parser state as the checker sees it.
  parse_state_t pst;
  logic [2:0]   p_version;
  logic [27:0]  p_tag_len;
  logic [28:0]  p_offset;
  logic [3:0]   p_hdr_count;
  logic [31:0]  p_frame_id;
  logic [31:0]  p_size;
  logic [27:0]  p_left;
  logic [3:0]   p_slot;

  parse_result_t pending [$];
  tag_byte_t     tag_bytes [$];
  stim_row_t     dir_rows [30];
  parse_result_t oldest;
  int            mismatches = 0;
  int            beats_sent = 0;
  int            burst_left = 0;
  int            hold_left = 0;
  bit            hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [3:0] slot_of(input bit short_ids, input logic [31:0] id);
    logic [3:0] found;
    found = NO_SLOT;
    if (short_ids) begin
      for (int i = 0; i < 4; i++) if (V2_IDS[i] == id) found = V2_SLOTS[i];
    end else begin
      for (int i = 0; i < 8; i++) if (V3_IDS[i] == id) found = 4'(i);
    end
    return found;
  endfunction

  // One byte through the parser; produced is set when a result comes out.
  task automatic parse_tag_byte(input logic [7:0] b, input logic s,
                                output bit produced, output parse_result_t r);
    int unsigned hlen;
    int unsigned idlen;
    logic [28:0] hdr_start;
    logic [28:0] room;
    logic [27:0] clamped;
    logic [3:0]  fslot;
    bit          last_flag;
    bit          emitting;
    produced = 1'b0;
    r = NO_RESULT;
    if (s) begin
      pst = PS_TAG_HDR;
      p_version = '0;
      p_tag_len = '0;
      p_offset = '0;
      p_hdr_count = '0;
      p_frame_id = '0;
      p_size = '0;
      p_left = '0;
      p_slot = NO_SLOT;
    end
    case (pst)
      PS_IDLE: ;
      PS_TAG_HDR: begin
        if (p_hdr_count < 3) p_frame_id = {8'h00, p_frame_id[15:0], b};
        else if (p_hdr_count == 3)
          p_version = (b == 8'd2) ? 3'd2 : ((b == 8'd3 || b == 8'd4) ? 3'd3 : 3'd0);
        else if (p_hdr_count >= 6) p_size = {4'h0, p_size[20:0], b[6:0]};
        if (p_hdr_count < 9) begin
          p_hdr_count++;
        end else begin
          p_hdr_count = '0;
          if (p_frame_id != TAG_MAGIC || p_version == 0) begin
            pst = PS_IDLE;
            produced = 1'b1;
            r.kind = KIND_ERROR;
          end else begin
            p_tag_len = p_size[27:0];
            p_offset = '0;
            pst = PS_FRAME_HDR;
          end
          p_frame_id = '0;
          p_size = '0;
        end
      end
      default: begin
        hlen = (p_version == 2) ? 6 : 10;
        idlen = (p_version == 2) ? 3 : 4;
        // A byte at or past the tag length, or padding where a frame would
        // start, closes the tag.
        if (p_offset >= p_tag_len || (pst == PS_FRAME_HDR && p_hdr_count == 0 && b == 0)) begin
          pst = PS_IDLE;
          p_hdr_count = '0;
          produced = 1'b1;
          r.kind = KIND_END;
        end else if (pst == PS_FRAME_HDR) begin
          if (p_hdr_count == 0) p_frame_id = '0;
          if (p_hdr_count < idlen) p_frame_id = {p_frame_id[23:0], b};
          if (p_hdr_count == idlen) p_size = '0;
          if (p_hdr_count >= idlen && p_hdr_count < 2 * idlen) p_size = {p_size[23:0], b};
          if (p_hdr_count < hlen - 1) begin
            p_hdr_count++;
            p_offset++;
          end else begin
            hdr_start = (p_offset >= hlen - 1) ? p_offset - 29'(hlen - 1) : '0;
            room = p_tag_len - hdr_start;
            clamped = (p_size > room) ? room[27:0] : p_size[27:0];
            fslot = slot_of(p_version == 2, p_frame_id);
            p_offset++;
            p_hdr_count = '0;
            p_slot = fslot;
            p_size = {4'h0, clamped};
            if (clamped == 0) begin
              if (fslot != NO_SLOT) begin
                produced = 1'b1;
                r.kind = KIND_EMPTY;
                r.slot = fslot[2:0];
              end
            end else begin
              p_left = clamped;
              pst = (fslot != NO_SLOT) ? PS_PAYLOAD : PS_SKIP;
            end
          end
        end else begin
          last_flag = (p_left <= 1) || (p_offset + 1 == p_tag_len);
          emitting = (pst == PS_PAYLOAD);
          p_left = (p_left > 0) ? p_left - 1'b1 : '0;
          p_offset++;
          if (p_left == 0) begin
            pst = PS_FRAME_HDR;
            p_hdr_count = '0;
          end
          if (emitting) begin
            produced = 1'b1;
            r = '{KIND_PAYLOAD, p_slot[2:0], b, p_size[27:0], last_flag};
          end
        end
      end
    endcase
  endtask

  // Offers one beat in the sender's burst pattern and records what it should
  // produce once it is taken.
  task automatic send_beat(input logic [7:0] b, input logic s,
                           input row_check_t chk, input parse_result_t typed);
    bit            produced;
    parse_result_t r;
    int unsigned   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 30);
      if (!hold_req && hold_left == 0) begin
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    tag_start <= s;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    parse_tag_byte(b, s, produced, r);
    case (chk)
      ROW_PREDICT: if (produced) pending.push_back(r);
      ROW_RESULT:  pending.push_back(typed);
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic s);
    tag_bytes.push_back('{b, s});
  endfunction

  // Appends one random tag to the byte list.
  task automatic queue_tag();
    int unsigned pick;
    int unsigned ver;
    int unsigned nframes;
    int unsigned nsend;
    logic [27:0] len;
    logic [31:0] id;
    logic [31:0] fsize;
    logic [7:0]  hdr [10];
    bit          short_ids;
    pick = $urandom_range(0, 99);
    ver = (pick < 30) ? 2 : (pick < 60) ? 3 : (pick < 85) ? 4 : $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    if (pick < 8) len = '0;
    else if (pick < 18) len = 28'($urandom());
    else len = 28'($urandom_range(1, 90));
    hdr[0] = 8'h49;
    hdr[1] = 8'h44;
    hdr[2] = 8'h33;
    hdr[3] = ver[7:0];
    hdr[4] = 8'($urandom_range(0, 255));
    hdr[5] = 8'($urandom_range(0, 255));
    // Syncsafe length, with the dropped top bit set at random.
    for (int i = 0; i < 4; i++)
      hdr[6 + i] = {1'($urandom_range(0, 1)), 7'((len >> (21 - 7 * i)) & 28'h7F)};
    if ($urandom_range(0, 19) == 0) hdr[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) begin
      // Header cut short by the next tag.
      nsend = $urandom_range(1, 9);
      for (int i = 0; i < nsend; i++) add_byte(hdr[i], i == 0);
      return;
    end
    for (int i = 0; i < 10; i++) add_byte(hdr[i], i == 0);
    if (hdr[0] != 8'h49 || hdr[1] != 8'h44 || hdr[2] != 8'h33 || ver < 2 || ver > 4) begin
      nsend = $urandom_range(0, 3);
      for (int i = 0; i < nsend; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    short_ids = (ver == 2);
    nframes = $urandom_range(0, 6);
    for (int f = 0; f < nframes; f++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        id = short_ids ? V2_IDS[$urandom_range(0, 3)] : V3_IDS[$urandom_range(0, 7)];
      end else if (pick < 92) begin
        id = $urandom();
        if (short_ids) id[23:16] = 8'($urandom_range(1, 255));
        else id[31:24] = 8'($urandom_range(1, 255));
      end else begin
        add_byte(8'h00, 1'b0);
        break;
      end
      if (!short_ids) add_byte(id[31:24], 1'b0);
      add_byte(id[23:16], 1'b0);
      add_byte(id[15:8], 1'b0);
      add_byte(id[7:0], 1'b0);
      pick = $urandom_range(0, 99);
      if (pick < 15) fsize = '0;
      else if (pick < 70) fsize = $urandom_range(1, 12);
      else if (pick < 85) fsize = $urandom_range(13, 40);
      else fsize = $urandom();
      if (short_ids) begin
        fsize[31:24] = 8'h00;
      end else begin
        add_byte(fsize[31:24], 1'b0);
      end
      add_byte(fsize[23:16], 1'b0);
      add_byte(fsize[15:8], 1'b0);
      add_byte(fsize[7:0], 1'b0);
      if (!short_ids) begin
        add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      nsend = (fsize > 40) ? $urandom_range(0, 40) : fsize;
      for (int i = 0; i < nsend; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
      if (fsize > 40) break;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      add_byte(8'h00, 1'b0);
    end else if (pick < 80) begin
      nsend = $urandom_range(1, 3);
      for (int i = 0; i < nsend; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Receiver: changing ready patterns, plus one long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned cyc;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("result with nothing expected: out_kind %0d", out_kind);
        mismatches++;
      end else begin
        oldest = pending.pop_front();
        if (out_kind !== oldest.kind) begin
          $error("out_kind: expected %0d, got %0d", oldest.kind, out_kind);
          mismatches++;
        end
        if (slot !== oldest.slot) begin
          $error("slot: expected %0d, got %0d", oldest.slot, slot);
          mismatches++;
        end
        if (payload_byte !== oldest.data) begin
          $error("payload_byte: expected %0h, got %0h", oldest.data, payload_byte);
          mismatches++;
        end
        if (frame_size !== oldest.size) begin
          $error("frame_size: expected %0d, got %0d", oldest.size, frame_size);
          mismatches++;
        end
        if (last_in_frame !== oldest.last) begin
          $error("last_in_frame: expected %0b, got %0b", oldest.last, last_in_frame);
          mismatches++;
        end
      end
    end
  end

  initial begin
    tag_byte_t nxt;
    bit        held;
    bit        drained;
    held = 1'b0;
    drained = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    tag_start = 1'b0;
    pst = PS_IDLE;
    p_version = '0;
    p_tag_len = '0;
    p_offset = '0;
    p_hdr_count = '0;
    p_frame_id = '0;
    p_size = '0;
    p_left = '0;
    p_slot = NO_SLOT;

    // Stray byte, a header with a bad version, then a version 2 tag of length
    // 8 whose oversized TT2 frame is clamped and cut off at the tag end.
    dir_rows = '{
      '{8'hFF, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h49, 1'b1, ROW_NONE,    NO_RESULT},
      '{8'h44, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h33, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'hFF, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h00, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h00, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h00, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h00, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h00, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h00, 1'b0, ROW_RESULT,  '{KIND_ERROR, 3'd0, 8'h00, 28'd0, 1'b0}},
      '{8'h49, 1'b1, ROW_NONE,    NO_RESULT},
      '{8'h44, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h33, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h02, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'hFF, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'hFF, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h80, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h80, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h80, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h88, 1'b0, ROW_NONE,    NO_RESULT},
      '{8'h54, 1'b0, ROW_PREDICT, NO_RESULT},
      '{8'h54, 1'b0, ROW_PREDICT, NO_RESULT},
      '{8'h32, 1'b0, ROW_PREDICT, NO_RESULT},
      '{8'hFF, 1'b0, ROW_PREDICT, NO_RESULT},
      '{8'hFF, 1'b0, ROW_PREDICT, NO_RESULT},
      '{8'hFF, 1'b0, ROW_PREDICT, NO_RESULT},
      '{8'h00, 1'b0, ROW_RESULT,  '{KIND_PAYLOAD, 3'd3, 8'h00, 28'd8, 1'b0}},
      '{8'hFF, 1'b0, ROW_RESULT,  '{KIND_PAYLOAD, 3'd3, 8'hFF, 28'd8, 1'b1}},
      '{8'h7A, 1'b0, ROW_RESULT,  '{KIND_END, 3'd0, 8'h00, 28'd0, 1'b0}}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].data, dir_rows[i].start, dir_rows[i].check, dir_rows[i].res);

    while (beats_sent < RANDOM_BEATS) begin
      if (!held && beats_sent >= 600) begin
        // A long TIT2 frame while the receiver holds off, so the parser
        // backs up and has to stall its input.
        held = 1'b1;
        hold_req = 1'b1;
        add_byte(8'h49, 1'b1);
        add_byte(8'h44, 1'b0);
        add_byte(8'h33, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h2C, 1'b0);
        add_byte(8'h54, 1'b0);
        add_byte(8'h49, 1'b0);
        add_byte(8'h54, 1'b0);
        add_byte(8'h32, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h22, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        for (int i = 0; i < 290; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'h00, 1'b0);
      end else if (!drained && beats_sent >= 1200) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
        @(negedge clk);
      end else begin
        queue_tag();
      end
      while (tag_bytes.size() != 0) begin
        nxt = tag_bytes.pop_front();
        send_beat(nxt.data, nxt.start, ROW_PREDICT, NO_RESULT);
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
